>>> src/sha256_byte_stream_hasher_top_macros.svh
// Assertion macros shared by the hasher RTL.
`ifndef SHA256_BYTE_STREAM_HASHER_TOP_MACROS_SVH
`define SHA256_BYTE_STREAM_HASHER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SHABSH_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("shabsh: same-cycle check failed");
`define SHABSH_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("shabsh: next-cycle check failed");
`else
`define SHABSH_ASSERT_IMP(lbl, ante, cons)
`define SHABSH_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> src/shabsh_pkg.sv
// Types, constants and round functions of the SHA-256 byte-stream hasher.
package shabsh_pkg;

	typedef logic [31:0] word_t;
	typedef logic [7:0][31:0] hash_t;

	// Inputs of one compression round and of the schedule update.
	typedef struct packed {
		hash_t       v;
		word_t       w0;
		word_t       w1;
		word_t       w9;
		word_t       w14;
		logic [5:0]  rnd;
	} round_in_t;

	// Working variables after the round and the next schedule word.
	typedef struct packed {
		hash_t v;
		word_t w;
	} round_out_t;

	localparam logic [5:0]  LEN_POS    = 6'd56;
	localparam logic [5:0]  LAST_BYTE  = 6'd63;
	localparam logic [5:0]  LAST_ROUND = 6'd63;
	localparam logic [7:0]  PAD_MARK   = 8'h80;
	localparam logic [63:0] BLOCK_BITS = 64'd512;

	// Element 0 holds chain word 0 (a), element 7 holds word 7 (h).
	localparam hash_t H_INIT = {32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

	function automatic word_t big_sig0(input word_t x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic word_t big_sig1(input word_t x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic word_t small_sig0(input word_t x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic word_t small_sig1(input word_t x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

	// Round constant table.
	function automatic word_t round_const(input logic [5:0] idx);
		word_t rc;
		case (idx)
			6'd0: rc = 32'h428a2f98;  6'd1: rc = 32'h71374491;  6'd2: rc = 32'hb5c0fbcf;
			6'd3: rc = 32'he9b5dba5;  6'd4: rc = 32'h3956c25b;  6'd5: rc = 32'h59f111f1;
			6'd6: rc = 32'h923f82a4;  6'd7: rc = 32'hab1c5ed5;  6'd8: rc = 32'hd807aa98;
			6'd9: rc = 32'h12835b01;  6'd10: rc = 32'h243185be; 6'd11: rc = 32'h550c7dc3;
			6'd12: rc = 32'h72be5d74; 6'd13: rc = 32'h80deb1fe; 6'd14: rc = 32'h9bdc06a7;
			6'd15: rc = 32'hc19bf174; 6'd16: rc = 32'he49b69c1; 6'd17: rc = 32'hefbe4786;
			6'd18: rc = 32'h0fc19dc6; 6'd19: rc = 32'h240ca1cc; 6'd20: rc = 32'h2de92c6f;
			6'd21: rc = 32'h4a7484aa; 6'd22: rc = 32'h5cb0a9dc; 6'd23: rc = 32'h76f988da;
			6'd24: rc = 32'h983e5152; 6'd25: rc = 32'ha831c66d; 6'd26: rc = 32'hb00327c8;
			6'd27: rc = 32'hbf597fc7; 6'd28: rc = 32'hc6e00bf3; 6'd29: rc = 32'hd5a79147;
			6'd30: rc = 32'h06ca6351; 6'd31: rc = 32'h14292967; 6'd32: rc = 32'h27b70a85;
			6'd33: rc = 32'h2e1b2138; 6'd34: rc = 32'h4d2c6dfc; 6'd35: rc = 32'h53380d13;
			6'd36: rc = 32'h650a7354; 6'd37: rc = 32'h766a0abb; 6'd38: rc = 32'h81c2c92e;
			6'd39: rc = 32'h92722c85; 6'd40: rc = 32'ha2bfe8a1; 6'd41: rc = 32'ha81a664b;
			6'd42: rc = 32'hc24b8b70; 6'd43: rc = 32'hc76c51a3; 6'd44: rc = 32'hd192e819;
			6'd45: rc = 32'hd6990624; 6'd46: rc = 32'hf40e3585; 6'd47: rc = 32'h106aa070;
			6'd48: rc = 32'h19a4c116; 6'd49: rc = 32'h1e376c08; 6'd50: rc = 32'h2748774c;
			6'd51: rc = 32'h34b0bcb5; 6'd52: rc = 32'h391c0cb3; 6'd53: rc = 32'h4ed8aa4a;
			6'd54: rc = 32'h5b9cca4f; 6'd55: rc = 32'h682e6ff3; 6'd56: rc = 32'h748f82ee;
			6'd57: rc = 32'h78a5636f; 6'd58: rc = 32'h84c87814; 6'd59: rc = 32'h8cc70208;
			6'd60: rc = 32'h90befffa; 6'd61: rc = 32'ha4506ceb; 6'd62: rc = 32'hbef9a3f7;
			6'd63: rc = 32'hc67178f2;
			default: rc = 32'h0;
		endcase
		return rc;
	endfunction

endpackage

>>> src/shabsh_in_if.sv
// Message byte channel: valid/ready handshake with the byte payload.
interface shabsh_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_valid;
	logic       message_end;

	modport source (output valid, output data_byte, output byte_valid, output message_end,
		input ready);
	modport sink (input valid, input data_byte, input byte_valid, input message_end,
		output ready);
endinterface

>>> src/shabsh_out_if.sv
// Digest channel: valid/ready handshake carrying one 64-bit digest chunk per beat.
interface shabsh_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] digest_chunk;
	logic [1:0]  chunk_index;
	logic        last_chunk;

	modport source (output valid, output digest_chunk, output chunk_index, output last_chunk,
		input ready);
	modport sink (input valid, input digest_chunk, input chunk_index, input last_chunk,
		output ready);
endinterface

>>> src/shabsh_round.sv
// One SHA-256 compression round plus one message schedule step.
module shabsh_round import shabsh_pkg::*; (
	input  round_in_t  rin,
	output round_out_t rout
);
	word_t t1;
	word_t t2;
	word_t chs;
	word_t maj;

	// Choose and majority on the working variables.
	always_comb begin
		chs = (rin.v[4] & rin.v[5]) ^ (~rin.v[4] & rin.v[6]);
		maj = (rin.v[0] & rin.v[1]) ^ (rin.v[0] & rin.v[2]) ^ (rin.v[1] & rin.v[2]);
		t1  = rin.v[7] + big_sig1(rin.v[4]) + chs + round_const(rin.rnd) + rin.w0;
		t2  = big_sig0(rin.v[0]) + maj;
	end

	// Rotate the working variables and insert the new a and e.
	always_comb begin
		rout.v[7] = rin.v[6];
		rout.v[6] = rin.v[5];
		rout.v[5] = rin.v[4];
		rout.v[4] = rin.v[3] + t1;
		rout.v[3] = rin.v[2];
		rout.v[2] = rin.v[1];
		rout.v[1] = rin.v[0];
		rout.v[0] = t1 + t2;
		rout.w    = rin.w0 + small_sig0(rin.w1) + rin.w9 + small_sig1(rin.w14);
	end
endmodule

>>> src/sha256_byte_stream_hasher_top.sv
// SHA-256 hasher top level: byte intake, padding, round sequencer and digest output.
//
// Usage: message bytes enter on the msg channel, one beat per byte. A beat with
// byte_valid low carries no byte; a beat with message_end high closes the message
// after its byte (if any), so an empty message is a single end beat without a byte.
// The digest leaves on the digest channel as four 64-bit beats, chunk 0 first
// (digest bits 255..192), the last one flagged by last_chunk.
// Intake: after a byte that neither completes a block nor ends the message, msg.ready
// stays high. A byte that completes a 64-byte block holds msg.ready low while the
// single round unit runs its 64 rounds and the result is folded into the chaining value.
// End of message: padding is shifted in one byte per cycle through the same block
// register, and each padded block is then compressed in the same way; a message whose
// tail leaves fewer than 9 free bytes needs two blocks.
// The four digest beats follow, and the block accepts no input until the receiver
// has taken all four; a stalled receiver simply holds the current beat.
// Reset loads the standard initial hash values and clears the byte count and the
// message length; the block is ready in the first cycle after reset is released.
`include "sha256_byte_stream_hasher_top_macros.svh"
module sha256_byte_stream_hasher_top import shabsh_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	shabsh_in_if.sink   msg,
	shabsh_out_if.source digest
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_COMP = 3'd1;
	localparam logic [2:0] ST_FOLD = 3'd2;
	localparam logic [2:0] ST_PAD  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]   state_q;
	logic [5:0]   fill_q;
	logic [63:0]  len_bits_q;
	logic [63:0]  total_q;
	logic         mark_q;
	logic         extra_q;
	logic         fin_q;
	logic         final_q;
	logic [5:0]   rnd_q;
	logic [1:0]   idx_q;
	hash_t        h_q;
	hash_t        v_q;
	logic [511:0] win_q;

	logic         acc;
	logic         out_acc;
	logic         wrap;
	logic [5:0]   fill_new;
	logic         shift_en;
	logic [7:0]   shift_byte;
	logic         len_sel;
	logic         extra_now;
	logic         blk_full;
	round_in_t    rin;
	round_out_t   rout;

	assign acc     = msg.valid && msg.ready;
	assign out_acc = digest.valid && digest.ready;
	assign wrap    = msg.byte_valid && (fill_q == LAST_BYTE);
	assign fill_new = msg.byte_valid ? (fill_q + 6'd1) : fill_q;

	// Padding byte selection: the marker, then zeros, then the length field.
	assign len_sel   = mark_q && !extra_q && (fill_q >= LEN_POS);
	assign extra_now = extra_q || (!mark_q && (fill_q >= LEN_POS));

	always_comb begin
		shift_en   = 1'b0;
		shift_byte = msg.data_byte;
		if (state_q == ST_IDLE) begin
			shift_en = acc && msg.byte_valid;
		end else if (state_q == ST_PAD) begin
			shift_en = 1'b1;
			if (!mark_q) begin
				shift_byte = PAD_MARK;
			end else if (len_sel) begin
				shift_byte = total_q[63:56];
			end else begin
				shift_byte = 8'h00;
			end
		end
	end

	assign blk_full = shift_en && (fill_q == LAST_BYTE);

	// Shared round unit fed from the working variables and the schedule window.
	always_comb begin
		rin.v   = v_q;
		rin.w0  = win_q[511:480];
		rin.w1  = win_q[479:448];
		rin.w9  = win_q[223:192];
		rin.w14 = win_q[63:32];
		rin.rnd = rnd_q;
	end

	shabsh_round u_round (
		.rin  (rin),
		.rout (rout)
	);

	// Datapath: block window, working variables and the padded length.
	always_ff @(posedge clk) begin
		if (shift_en) begin
			win_q <= {win_q[503:0], shift_byte};
		end else if (state_q == ST_COMP) begin
			win_q <= {win_q[479:0], rout.w};
		end
		if (blk_full) begin
			v_q <= h_q;
		end else if (state_q == ST_COMP) begin
			v_q <= rout.v;
		end
		if ((state_q == ST_IDLE) && acc && msg.message_end) begin
			total_q <= len_bits_q + (wrap ? BLOCK_BITS : 64'd0) + {55'd0, fill_new, 3'b000};
		end else if ((state_q == ST_PAD) && len_sel) begin
			total_q <= {total_q[55:0], 8'h00};
		end
	end

	// Sequencer and chaining state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fill_q     <= '0;
			len_bits_q <= '0;
			mark_q     <= 1'b0;
			extra_q    <= 1'b0;
			fin_q      <= 1'b0;
			final_q    <= 1'b0;
			rnd_q      <= '0;
			idx_q      <= '0;
			h_q        <= H_INIT;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						fill_q <= fill_new;
						if (msg.message_end) begin
							mark_q  <= 1'b0;
							extra_q <= 1'b0;
						end
						if (wrap) begin
							len_bits_q <= len_bits_q + BLOCK_BITS;
							state_q    <= ST_COMP;
							rnd_q      <= '0;
							fin_q      <= msg.message_end;
							final_q    <= 1'b0;
						end else if (msg.message_end) begin
							state_q <= ST_PAD;
							fin_q   <= 1'b1;
						end
					end
				end
				ST_PAD: begin
					fill_q  <= fill_q + 6'd1;
					mark_q  <= 1'b1;
					extra_q <= extra_now;
					if (fill_q == LAST_BYTE) begin
						state_q <= ST_COMP;
						rnd_q   <= '0;
						final_q <= !extra_now;
					end
				end
				ST_COMP: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == LAST_ROUND) begin
						state_q <= ST_FOLD;
					end
				end
				ST_FOLD: begin
					for (int i = 0; i < 8; i++) begin
						h_q[i] <= h_q[i] + v_q[i];
					end
					if (final_q) begin
						state_q <= ST_OUT;
						idx_q   <= '0;
					end else if (fin_q) begin
						state_q <= ST_PAD;
						extra_q <= 1'b0;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (out_acc) begin
						idx_q <= idx_q + 2'd1;
						if (idx_q == 2'd3) begin
							h_q        <= H_INIT;
							fill_q     <= '0;
							len_bits_q <= '0;
							fin_q      <= 1'b0;
							final_q    <= 1'b0;
							state_q    <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Channel outputs.
	assign msg.ready           = (state_q == ST_IDLE);
	assign digest.valid        = (state_q == ST_OUT);
	assign digest.digest_chunk = {h_q[{idx_q, 1'b0}], h_q[{idx_q, 1'b1}]};
	assign digest.chunk_index  = idx_q;
	assign digest.last_chunk   = (idx_q == 2'd3);

	// Checks on the sequencer.
	`SHABSH_ASSERT_IMP(a_no_intake_while_out, digest.valid, !msg.ready)
	`SHABSH_ASSERT_NXT(a_rounds_then_fold, (state_q == ST_COMP) && (rnd_q == LAST_ROUND), state_q == ST_FOLD)
	`SHABSH_ASSERT_NXT(a_clean_after_digest, out_acc && digest.last_chunk, (state_q == ST_IDLE) && (fill_q == 6'd0) && (len_bits_q == 64'd0))
	`SHABSH_ASSERT_IMP(a_pad_fill_full_enters_comp, (state_q == ST_PAD) && (fill_q == LAST_BYTE), blk_full)
endmodule
